### hdl/bqs_pkg.sv
// ----------------------------------------------------------------------------
// bqs_pkg: shared types, constants and helpers of the Bayer quad saturation
// Constants, register indexes and lane arithmetic used by all pipeline parts.
// ----------------------------------------------------------------------------
package bqs_pkg;

	localparam int PIX_W         = 16;
	localparam int SAT_W         = 14;
	localparam int SAT_FRAC_BITS = 12;
	localparam int UNITY         = 1 << SAT_FRAC_BITS;
	localparam int SAT_MAX       = (UNITY * 5) >> 1;
	// Largest distance from unity that still counts as unity.
	localparam int NEAR_MAX      = (5 * UNITY - 1) / 1000;
	localparam int DIV_STEPS     = PIX_W;
	localparam int NUM_W         = 2 * PIX_W;
	localparam int G2_W          = PIX_W + 1;
	localparam int DIFF_W        = PIX_W + 2;
	localparam int PROD_W        = DIFF_W + SAT_W + 1;
	localparam int T_W           = PROD_W + 1;
	localparam int IDX_W         = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_BLACK_0 = 3'd0,
		REG_BLACK_1 = 3'd1,
		REG_BLACK_2 = 3'd2,
		REG_BLACK_3 = 3'd3,
		REG_WHITE   = 3'd4,
		REG_CFA     = 3'd5,
		REG_SAT     = 3'd6
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [3:0] quad_t;
	typedef logic [NUM_W-1:0] word_t;
	typedef word_t [3:0] word_quad_t;

	// Settings as the datapath sees them; sat is already limited to SAT_MAX.
	typedef struct packed {
		quad_t            black;
		pix_t             white;
		logic [1:0]       cfa;
		logic [SAT_W-1:0] sat;
		logic             bypass;
	} cfg_t;

	function automatic pix_t range_of(pix_t white, pix_t black);
		return (white > black) ? pix_t'(white - black) : pix_t'(1);
	endfunction

	// Red sits at position cfa and blue at its mirror, so greens are the rest.
	function automatic logic is_green(logic [1:0] pos, logic [1:0] cfa);
		return (pos != cfa) && (pos != ~cfa);
	endfunction

	// One restoring division step: accumulator holds {remainder, dividend/quotient}.
	function automatic word_t div_step(word_t acc, pix_t r);
		logic [PIX_W:0] top;
		logic [PIX_W:0] diff;
		top  = acc[NUM_W-1:PIX_W-1];
		diff = top - {1'b0, r};
		if (top >= {1'b0, r})
			return {diff[PIX_W-1:0], acc[PIX_W-2:0], 1'b1};
		else
			return {acc[NUM_W-2:0], 1'b0};
	endfunction

	// Round to nearest at half scale and clamp to the sample range.
	function automatic pix_t push_round(logic signed [T_W-1:0] t);
		logic signed [T_W-1:0] u;
		u = (t + T_W'(UNITY)) >>> (SAT_FRAC_BITS + 1);
		if (t < 0)
			return '0;
		else if (u > T_W'(65535))
			return pix_t'(65535);
		else
			return u[PIX_W-1:0];
	endfunction

	// Quotient by 65535 for values below 65535 * 65536.
	function automatic pix_t div_65535(word_t x);
		logic [NUM_W+1:0] y;
		y = {2'b0, x} + (NUM_W+2)'(x >> PIX_W) + (NUM_W+2)'(1);
		return y[NUM_W-1:PIX_W];
	endfunction

endpackage

### hdl/bqs_front.sv
// ----------------------------------------------------------------------------
// bqs_front: black level removal and division setup
// Two stages: signal above black per sample, then the scaled numerator.
// ----------------------------------------------------------------------------
module bqs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  bqs_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  bqs_pkg::quad_t     in_quad,
	output logic               out_valid,
	input  logic               out_ready,
	output bqs_pkg::word_quad_t out_num,
	output logic [3:0]         out_clamp,
	output bqs_pkg::quad_t     out_raw
);

	logic               vld_s1, vld_s2, adv1, adv2;
	bqs_pkg::quad_t     sig_c, sig_s1, raw_s1, raw_s2;
	logic [3:0]         clamp_c, clamp_s1, clamp_s2;
	bqs_pkg::word_quad_t num_c, num_s2;
	bqs_pkg::pix_t      rng [4];

	assign adv2     = !vld_s2 || out_ready;
	assign adv1     = !vld_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rng[i]     = bqs_pkg::range_of(cfg.white, cfg.black[i]);
			sig_c[i]   = (in_quad[i] > cfg.black[i]) ?
				bqs_pkg::pix_t'(in_quad[i] - cfg.black[i]) : '0;
			clamp_c[i] = sig_c[i] >= rng[i];
			// signal * 65535 + range / 2
			num_c[i]   = {sig_s1[i], {bqs_pkg::PIX_W{1'b0}}}
				- {{bqs_pkg::PIX_W{1'b0}}, sig_s1[i]}
				+ {{(bqs_pkg::PIX_W+1){1'b0}}, rng[i][bqs_pkg::PIX_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			sig_s1   <= sig_c;
			clamp_s1 <= clamp_c;
			raw_s1   <= in_quad;
		end
		if (adv2 && vld_s1) begin
			num_s2   <= num_c;
			clamp_s2 <= clamp_s1;
			raw_s2   <= raw_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_num   = num_s2;
	assign out_clamp = clamp_s2;
	assign out_raw   = raw_s2;

endmodule

### hdl/bqs_div.sv
// ----------------------------------------------------------------------------
// bqs_div: pipelined restoring divider, four lanes
// One quotient bit per stage; saturated lanes give full scale.
// ----------------------------------------------------------------------------
module bqs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bqs_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  bqs_pkg::word_quad_t in_num,
	input  logic [3:0]         in_clamp,
	input  bqs_pkg::quad_t     in_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output bqs_pkg::quad_t     out_n,
	output bqs_pkg::quad_t     out_raw
);

	localparam int N = bqs_pkg::DIV_STEPS;

	logic                [N:0]   vld_s;
	logic                [N+1:1] adv;
	bqs_pkg::word_quad_t         acc_s   [N+1];
	logic                [3:0]   clamp_s [N+1];
	bqs_pkg::quad_t              raw_s   [N+1];
	bqs_pkg::quad_t              rng;

	always_comb begin
		for (int i = 0; i < 4; i++)
			rng[i] = bqs_pkg::range_of(cfg.white, cfg.black[i]);
	end

	assign vld_s[0]   = in_valid;
	assign acc_s[0]   = in_num;
	assign clamp_s[0] = in_clamp;
	assign raw_s[0]   = in_raw;
	assign adv[N+1]   = out_ready;
	assign in_ready   = adv[1];

	for (genvar k = 1; k <= N; k++) begin : g_step
		assign adv[k] = !vld_s[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (adv[k])
				vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv[k] && vld_s[k-1]) begin
				for (int i = 0; i < 4; i++)
					acc_s[k][i] <= bqs_pkg::div_step(acc_s[k-1][i], rng[i]);
				clamp_s[k] <= clamp_s[k-1];
				raw_s[k]   <= raw_s[k-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			out_n[i] = clamp_s[N][i] ? '1 : acc_s[N][i][bqs_pkg::PIX_W-1:0];
	end

	assign out_valid = vld_s[N];
	assign out_raw   = raw_s[N];

endmodule

### hdl/bqs_push.sv
// ----------------------------------------------------------------------------
// bqs_push: saturation stage of the Bayer quad pipeline
// Wraps the saturation core so the top level sees one stage block.
// ----------------------------------------------------------------------------
module bqs_push (
	input  logic           clk,
	input  logic           arst_n,
	input  bqs_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  bqs_pkg::quad_t in_n,
	input  bqs_pkg::quad_t in_raw,
	output logic           out_valid,
	input  logic           out_ready,
	output bqs_pkg::pix_t  out_vr,
	output bqs_pkg::pix_t  out_vb,
	output bqs_pkg::quad_t out_raw
);

	bqs_push_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.in_valid(in_valid), .in_ready(in_ready), .in_n(in_n), .in_raw(in_raw),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_vr(out_vr), .out_vb(out_vb), .out_raw(out_raw)
	);

endmodule

### hdl/bqs_push_core.sv
// ----------------------------------------------------------------------------
// bqs_push_core: saturation of red and blue around the green mean
// Stages: green sum and differences, products, rounding with clamp.
// ----------------------------------------------------------------------------
module bqs_push_core (
	input  logic           clk,
	input  logic           arst_n,
	input  bqs_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  bqs_pkg::quad_t in_n,
	input  bqs_pkg::quad_t in_raw,
	output logic           out_valid,
	input  logic           out_ready,
	output bqs_pkg::pix_t  out_vr,
	output bqs_pkg::pix_t  out_vb,
	output bqs_pkg::quad_t out_raw
);

	logic vld_s1, vld_s2, vld_s3, adv1, adv2, adv3;
	logic        [bqs_pkg::G2_W-1:0]   g2_c, g2_s1, g2_s2;
	logic signed [bqs_pkg::DIFF_W-1:0] dr_c, db_c, dr_s1, db_s1;
	logic signed [bqs_pkg::PROD_W-1:0] pr_s2, pb_s2;
	logic signed [bqs_pkg::T_W-1:0]    base, tr, tb;
	bqs_pkg::quad_t raw_s1, raw_s2, raw_s3;
	bqs_pkg::pix_t  vr_s3, vb_s3;

	assign adv3     = !vld_s3 || out_ready;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		g2_c = '0;
		for (int i = 0; i < 4; i++)
			if (bqs_pkg::is_green(2'(i), cfg.cfa))
				g2_c = g2_c + bqs_pkg::G2_W'(in_n[i]);
		dr_c = $signed({1'b0, in_n[cfg.cfa], 1'b0}) - $signed({1'b0, g2_c});
		db_c = $signed({1'b0, in_n[~cfg.cfa], 1'b0}) - $signed({1'b0, g2_c});
		base = $signed({{(bqs_pkg::T_W-bqs_pkg::G2_W-bqs_pkg::SAT_FRAC_BITS){1'b0}},
			g2_s2, {bqs_pkg::SAT_FRAC_BITS{1'b0}}});
		tr   = base + bqs_pkg::T_W'(pr_s2);
		tb   = base + bqs_pkg::T_W'(pb_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			g2_s1  <= g2_c;
			dr_s1  <= dr_c;
			db_s1  <= db_c;
			raw_s1 <= in_raw;
		end
		if (adv2 && vld_s1) begin
			g2_s2  <= g2_s1;
			pr_s2  <= dr_s1 * $signed({1'b0, cfg.sat});
			pb_s2  <= db_s1 * $signed({1'b0, cfg.sat});
			raw_s2 <= raw_s1;
		end
		if (adv3 && vld_s2) begin
			vr_s3  <= bqs_pkg::push_round(tr);
			vb_s3  <= bqs_pkg::push_round(tb);
			raw_s3 <= raw_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_vr    = vr_s3;
	assign out_vb    = vb_s3;
	assign out_raw   = raw_s3;

endmodule

### hdl/bqs_encode.sv
// ----------------------------------------------------------------------------
// bqs_encode: conversion back to raw codes and output register
// Stages: scale by range, divide by full scale, add black and cap at white.
// ----------------------------------------------------------------------------
module bqs_encode (
	input  logic           clk,
	input  logic           arst_n,
	input  bqs_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  bqs_pkg::pix_t  in_vr,
	input  bqs_pkg::pix_t  in_vb,
	input  bqs_pkg::quad_t in_raw,
	output logic           out_valid,
	input  logic           out_ready,
	output bqs_pkg::quad_t out_quad
);

	logic vld_s1, vld_s2, vld_s3, adv1, adv2, adv3;
	bqs_pkg::word_t pr_s1, pb_s1;
	bqs_pkg::pix_t  qr_s2, qb_s2, br, bb, rr, rb;
	logic [bqs_pkg::PIX_W:0] cr, cb;
	bqs_pkg::quad_t raw_s1, raw_s2, quad_c, quad_s3;

	assign adv3     = !vld_s3 || out_ready;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		br = cfg.black[cfg.cfa];
		bb = cfg.black[~cfg.cfa];
		rr = bqs_pkg::range_of(cfg.white, br);
		rb = bqs_pkg::range_of(cfg.white, bb);
		cr = {1'b0, br} + {1'b0, qr_s2};
		cb = {1'b0, bb} + {1'b0, qb_s2};
		quad_c = raw_s2;
		if (!cfg.bypass) begin
			quad_c[cfg.cfa]  = (cr > {1'b0, cfg.white}) ? cfg.white : cr[bqs_pkg::PIX_W-1:0];
			quad_c[~cfg.cfa] = (cb > {1'b0, cfg.white}) ? cfg.white : cb[bqs_pkg::PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			pr_s1  <= in_vr * rr;
			pb_s1  <= in_vb * rb;
			raw_s1 <= in_raw;
		end
		if (adv2 && vld_s1) begin
			qr_s2  <= bqs_pkg::div_65535(pr_s1 + bqs_pkg::NUM_W'(32767));
			qb_s2  <= bqs_pkg::div_65535(pb_s1 + bqs_pkg::NUM_W'(32767));
			raw_s2 <= raw_s1;
		end
		if (adv3 && vld_s2)
			quad_s3 <= quad_c;
	end

	assign out_valid = vld_s3;
	assign out_quad  = quad_s3;

endmodule

### hdl/bayer_quad_saturation.sv
// ----------------------------------------------------------------------------
// bayer_quad_saturation: saturation adjust of 2x2 raw Bayer quads
// Top level: settings registers, pipeline chain and stream ports.
// ----------------------------------------------------------------------------
// The block takes one 2x2 quad per clock unless the output stalls and returns
// it with red and blue pushed away from the green mean by the Q12 saturation
// factor; greens pass unchanged, and the whole quad passes unchanged while the
// factor lies within 20 of unity. The pipeline is 2 front stages, 16 divider
// stages (one quotient bit per stage), 3 saturation stages and 3 re-encoding
// stages, the last of which drives the output port. Every stage holds its word
// while stalled and fills bubbles, so the input keeps taking words while a
// finished word waits at the output. Settings must be written through the cfg
// port only while no word is in flight; the block does not enforce it. The
// port always takes a write, and writes to indexes past the list are dropped.
module bayer_quad_saturation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: pixel_top_left, pixel_top_right, pixel_bottom_left,
	// pixel_bottom_right, 16 bits each, from bit 0 up
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: out_top_left, out_top_right, out_bottom_left, out_bottom_right,
	// 16 bits each, from bit 0 up
	output logic [63:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	bqs_pkg::quad_t      black_q;
	bqs_pkg::pix_t       white_q;
	logic [1:0]          cfa_q;
	logic [bqs_pkg::SAT_W-1:0] sat_q, sat_eff, sat_dist;
	bqs_pkg::cfg_t       cfg;

	logic                f_valid, f_ready, d_valid, d_ready, p_valid, p_ready;
	bqs_pkg::word_quad_t f_num;
	logic [3:0]          f_clamp;
	bqs_pkg::quad_t      f_raw, d_n, d_raw, p_raw;
	bqs_pkg::pix_t       p_vr, p_vb;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q <= '0;
			white_q <= 16'hFFFF;
			cfa_q   <= '0;
			sat_q   <= bqs_pkg::SAT_W'(bqs_pkg::UNITY);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bqs_pkg::REG_BLACK_0: black_q[0] <= cfg_data;
				bqs_pkg::REG_BLACK_1: black_q[1] <= cfg_data;
				bqs_pkg::REG_BLACK_2: black_q[2] <= cfg_data;
				bqs_pkg::REG_BLACK_3: black_q[3] <= cfg_data;
				bqs_pkg::REG_WHITE:   white_q    <= cfg_data;
				bqs_pkg::REG_CFA:     cfa_q      <= cfg_data[1:0];
				bqs_pkg::REG_SAT:     sat_q      <= cfg_data[bqs_pkg::SAT_W-1:0];
				default: ;
			endcase
		end
	end

	// Factor limited to 2.5, and its distance from unity for the bypass test.
	always_comb begin
		sat_eff  = (sat_q > bqs_pkg::SAT_W'(bqs_pkg::SAT_MAX)) ?
			bqs_pkg::SAT_W'(bqs_pkg::SAT_MAX) : sat_q;
		sat_dist = (sat_eff >= bqs_pkg::SAT_W'(bqs_pkg::UNITY)) ?
			sat_eff - bqs_pkg::SAT_W'(bqs_pkg::UNITY) :
			bqs_pkg::SAT_W'(bqs_pkg::UNITY) - sat_eff;
		cfg.black  = black_q;
		cfg.white  = white_q;
		cfg.cfa    = cfa_q;
		cfg.sat    = sat_eff;
		cfg.bypass = sat_dist <= bqs_pkg::SAT_W'(bqs_pkg::NEAR_MAX);
	end

	bqs_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_quad(s_axis_tdata),
		.out_valid(f_valid), .out_ready(f_ready),
		.out_num(f_num), .out_clamp(f_clamp), .out_raw(f_raw)
	);

	bqs_div u_div (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.in_valid(f_valid), .in_ready(f_ready),
		.in_num(f_num), .in_clamp(f_clamp), .in_raw(f_raw),
		.out_valid(d_valid), .out_ready(d_ready), .out_n(d_n), .out_raw(d_raw)
	);

	bqs_push u_push (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.in_valid(d_valid), .in_ready(d_ready), .in_n(d_n), .in_raw(d_raw),
		.out_valid(p_valid), .out_ready(p_ready),
		.out_vr(p_vr), .out_vb(p_vb), .out_raw(p_raw)
	);

	bqs_encode u_encode (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.in_valid(p_valid), .in_ready(p_ready),
		.in_vr(p_vr), .in_vb(p_vb), .in_raw(p_raw),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_quad(m_axis_tdata)
	);

endmodule

### hdl/bqs_checker.sv
// ----------------------------------------------------------------------------
// bqs_checker: port-level checks of the Bayer quad saturation
// Watches the stream and settings ports of the top level.
// ----------------------------------------------------------------------------
module bqs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [15:0] cfg_data
);

	// A held output word stays put until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// The input only backs off when the pipeline is full behind a stalled output.
	a_in_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a stalled output");

	// Settings writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("settings write refused");

endmodule

bind bayer_quad_saturation bqs_checker u_bqs_checker (.*);
